// File: rtl/vkv_pkg.sv
package vkv_pkg;

	localparam int KEY_W   = 256;
	localparam int VAL_W   = 256;
	localparam int VER_W   = 64;
	localparam int GVER_W  = 32;
	localparam int SUM_W   = 13;   // sum of 32 bytes fits in 13 bits
	localparam int IN_W    = KEY_W + VAL_W + GVER_W;
	localparam int OUT_W   = VAL_W + VER_W;
	localparam logic [VER_W-1:0] VER_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		REQ_STORE_INC = 2'd0,
		REQ_STORE_VER = 2'd1,
		REQ_REMOVE    = 2'd2,
		REQ_LOOKUP    = 2'd3
	} req_type_t;

	typedef struct packed {
		logic [GVER_W-1:0] given_version;
		logic [VAL_W-1:0]  value;
		logic [KEY_W-1:0]  key;
		req_type_t         req_type;
	} req_t;

	localparam int REQ_W = $bits(req_t);

	typedef enum logic [1:0] {
		F_IDLE,
		F_SUM,
		F_MUL,
		F_MOD
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_EXEC
	} back_state_t;

endpackage

// File: rtl/vkv_front.sv
module vkv_front import vkv_pkg::*; #(
	parameter int BUCKETS = 1024,
	parameter int BW      = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,
	input  logic [1:0]           s_tuser,
	output logic                 push,
	input  logic                 full,
	output req_t                 push_req,
	output logic [BW-1:0]        push_bucket
);

	// floor reciprocal: quotient estimate is exact or one short
	localparam int SH = 24;
	localparam logic [20:0] RECIP = 21'((1 << SH) / BUCKETS);

	front_state_t state_q, state_d;
	req_t              req_q;
	logic [SUM_W-1:0]  sum_q, quot_q, sum_c, rem_c;
	logic [33:0]       prod_c;
	logic [25:0]       back_c;
	logic [10:0]       part_c [4];

	always_comb begin
		for (int w = 0; w < 4; w++) begin
			part_c[w] = '0;
			for (int b = 0; b < 8; b++)
				part_c[w] = part_c[w] + 11'(req_q.key[w*64 + b*8 +: 8]);
		end
		sum_c = 13'(part_c[0]) + 13'(part_c[1]) + 13'(part_c[2]) + 13'(part_c[3]);
		prod_c = 34'(sum_q) * 34'(RECIP);
		back_c = 26'(quot_q) * 26'(BUCKETS);
		rem_c = sum_q - back_c[SUM_W-1:0];
		if (rem_c >= SUM_W'(BUCKETS))
			rem_c = rem_c - SUM_W'(BUCKETS);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (s_tvalid) state_d = F_SUM;
			F_SUM: state_d = F_MUL;
			F_MUL: state_d = F_MOD;
			F_MOD: if (!full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == F_IDLE);
		push     = (state_q == F_MOD) && !full;
	end

	assign push_req    = req_q;
	assign push_bucket = rem_c[BW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q.req_type      <= req_type_t'(s_tuser);
			req_q.key           <= s_tdata[KEY_W-1:0];
			req_q.value         <= s_tdata[KEY_W +: VAL_W];
			req_q.given_version <= s_tdata[KEY_W+VAL_W +: GVER_W];
		end
		if (state_q == F_SUM)
			sum_q <= sum_c;
		if (state_q == F_MUL)
			quot_q <= SUM_W'(prod_c[33:SH]);
	end

endmodule

// File: rtl/vkv_fifo.sv
module vkv_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         nempty,
	output logic [W-1:0] rdata
);

	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign nempty = (cnt_q != 2'd0);
	assign rdata  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

endmodule

// File: rtl/vkv_back.sv
module vkv_back import vkv_pkg::*; #(
	parameter int BUCKETS = 1024,
	parameter int WAYS    = 4,
	parameter int BW      = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_nempty,
	output logic               q_pop,
	input  req_t               q_req,
	input  logic [BW-1:0]      q_bucket,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,
	output logic [1:0]         m_tuser
);

	localparam int KR = WAYS * KEY_W;
	localparam int VR = WAYS * VER_W;

	logic [KR-1:0]    key_mem [BUCKETS];
	logic [KR-1:0]    val_mem [BUCKETS];
	logic [VR-1:0]    ver_mem [BUCKETS];
	logic [WAYS-1:0]  vld_mem [BUCKETS];

	logic [KR-1:0]    key_rd_s1, val_rd_s1, key_wr;
	logic [KR-1:0]    val_wr;
	logic [VR-1:0]    ver_rd_s1, ver_wr;
	logic [WAYS-1:0]  vld_rd_s1, vld_wd;
	logic [BW-1:0]    vld_addr, clr_q;
	logic             vld_we, row_we, out_free;

	back_state_t      state_q, state_d;
	req_t             cur_q;
	logic [BW-1:0]    bkt_q;

	logic [WAYS-1:0]  hit_v, free_v, tgt_v;
	logic             any_hit, any_free, refuse, is_store;
	logic [VAL_W-1:0] hit_val;
	logic [VER_W-1:0] hit_ver, new_ver, gver, wr_ver;

	logic             m_valid_q, found_q, status_q;
	logic [VAL_W-1:0] read_q;
	logic [VER_W-1:0] ver_q;

	// bucket search, lowest way first
	always_comb begin
		any_hit  = 1'b0;
		any_free = 1'b0;
		hit_val  = '0;
		hit_ver  = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit_v[w]  = vld_rd_s1[w] && (key_rd_s1[w*KEY_W +: KEY_W] == cur_q.key);
			free_v[w] = !vld_rd_s1[w];
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit_v[w]) begin
				any_hit = 1'b1;
				hit_val = val_rd_s1[w*VAL_W +: VAL_W];
				hit_ver = ver_rd_s1[w*VER_W +: VER_W];
			end
			if (free_v[w])
				any_free = 1'b1;
		end
		tgt_v = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (any_hit ? hit_v[w] : free_v[w]) begin
				tgt_v = '0;
				tgt_v[w] = 1'b1;
			end
		end
	end

	always_comb begin
		is_store = (cur_q.req_type == REQ_STORE_INC) || (cur_q.req_type == REQ_STORE_VER);
		refuse   = is_store && !any_hit && !any_free;
		gver     = {{(VER_W-GVER_W){cur_q.given_version[GVER_W-1]}}, cur_q.given_version};
		if (!any_hit)
			new_ver = 64'd1;
		else if (hit_ver == VER_MAX)
			new_ver = VER_MAX;
		else
			new_ver = hit_ver + 64'd1;
		wr_ver = (cur_q.req_type == REQ_STORE_INC) ? new_ver : gver;
		key_wr = key_rd_s1;
		val_wr = val_rd_s1;
		ver_wr = ver_rd_s1;
		for (int w = 0; w < WAYS; w++) begin
			if (tgt_v[w]) begin
				key_wr[w*KEY_W +: KEY_W] = cur_q.key;
				val_wr[w*VAL_W +: VAL_W] = cur_q.value;
				ver_wr[w*VER_W +: VER_W] = wr_ver;
			end
		end
	end

	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_CLEAR: if (clr_q == BW'(BUCKETS - 1)) state_d = B_IDLE;
			B_IDLE: if (q_nempty) state_d = B_EXEC;
			B_EXEC: if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (state_q == B_IDLE) && q_nempty;
		row_we   = (state_q == B_EXEC) && out_free && is_store && !refuse;
		vld_we   = 1'b0;
		vld_addr = bkt_q;
		vld_wd   = vld_rd_s1;
		unique case (state_q)
			B_CLEAR: begin
				vld_we   = 1'b1;
				vld_addr = clr_q;
				vld_wd   = '0;
			end
			B_EXEC: begin
				if (out_free && row_we) begin
					vld_we = 1'b1;
					vld_wd = vld_rd_s1 | tgt_v;
				end else if (out_free && cur_q.req_type == REQ_REMOVE && any_hit) begin
					vld_we = 1'b1;
					vld_wd = vld_rd_s1 & ~hit_v;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR)
				clr_q <= clr_q + BW'(1);
			if (state_q == B_EXEC && out_free)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q     <= q_req;
			bkt_q     <= q_bucket;
			key_rd_s1 <= key_mem[q_bucket];
			val_rd_s1 <= val_mem[q_bucket];
			ver_rd_s1 <= ver_mem[q_bucket];
			vld_rd_s1 <= vld_mem[q_bucket];
		end
		if (row_we) begin
			key_mem[bkt_q] <= key_wr;
			val_mem[bkt_q] <= val_wr;
			ver_mem[bkt_q] <= ver_wr;
		end
		if (vld_we)
			vld_mem[vld_addr] <= vld_wd;
		if (state_q == B_EXEC && out_free) begin
			found_q  <= any_hit;
			status_q <= refuse;
			read_q   <= (cur_q.req_type == REQ_LOOKUP && any_hit) ? hit_val : '0;
			if (cur_q.req_type == REQ_STORE_INC && !refuse)
				ver_q <= new_ver;
			else if (cur_q.req_type == REQ_LOOKUP && any_hit)
				ver_q <= hit_ver;
			else
				ver_q <= '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {ver_q, read_q};
	assign m_tuser  = {status_q, found_q};

endmodule

// File: rtl/versioned_kv_hash_table.sv
// Versioned key-value hash table, 256-bit keys and values, 64-bit versions.
// Input stream s_*: one request per transfer. Output stream m_*: exactly one
// result per request, in request order.
// Front end: registers the request and forms the bucket (byte sum, then a
// reciprocal multiply and one correction) in states F_SUM, F_MUL and F_MOD,
// then hands the request to a two-entry queue; F_MOD waits while it is full.
// Back end: one bucket row read from synchronous memory, then the compare,
// the write-back and the result register; it pops the next request only
// after B_EXEC has finished. Sustained throughput is set by the front end,
// which takes no new request until it has pushed the last one.
// After reset the valid bits are swept clear, one bucket a cycle;
// requests queue up meanwhile and are served afterwards.
// When m_tready is low the result register holds, the back end waits on
// it and the queue and front end fill, after which s_tready goes low.
module versioned_kv_hash_table import vkv_pkg::*; #(
	parameter int BUCKETS = 1024,
	parameter int WAYS    = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // key_w0..key_w3, value_w0..value_w3, given_version
	input  logic [1:0]       s_tuser,   // req_type
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // read_w0..read_w3, entry_version
	output logic [1:0]       m_tuser    // found, status
);

	localparam int BW = $clog2(BUCKETS);
	localparam int FW = REQ_W + BW;

	logic          push, full, nempty, pop;
	req_t          f_req, b_req;
	logic [BW-1:0] f_bkt, b_bkt;
	logic [FW-1:0] q_rdata;

	vkv_front #(.BUCKETS(BUCKETS), .BW(BW)) u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.push, .full, .push_req(f_req), .push_bucket(f_bkt)
	);

	vkv_fifo #(.W(FW)) u_fifo (
		.clk, .arst_n, .push, .wdata({f_bkt, f_req}), .full,
		.pop, .nempty, .rdata(q_rdata)
	);

	assign b_req = q_rdata[REQ_W-1:0];
	assign b_bkt = q_rdata[FW-1:REQ_W];

	vkv_back #(.BUCKETS(BUCKETS), .WAYS(WAYS), .BW(BW)) u_back (
		.clk, .arst_n, .q_nempty(nempty), .q_pop(pop), .q_req(b_req), .q_bucket(b_bkt),
		.m_tvalid, .m_tready, .m_tdata, .m_tuser
	);

endmodule

// File: rtl/vkv_checker.sv
module vkv_checker import vkv_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [1:0]       m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed while stalled");

	a_full_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata == '0)
		else $error("refused insert with data or hit");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[VAL_W-1:0] == '0)
		else $error("miss returned value data");

endmodule

bind versioned_kv_hash_table vkv_checker u_chk (.*);
